FILE: rtl/core/lottery_winner_picker_macros.svh
// assertion macros shared by the lottery winner picker checkers
// expects clk and arst_n to be visible where a macro is used
`ifndef LOTTERY_WINNER_PICKER_MACROS_SVH
`define LOTTERY_WINNER_PICKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LWP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LWP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lwp_pkg.sv
// shared types and constants of the lottery winner picker
// no dependencies
package lwp_pkg;

	localparam int NUM_SLOTS       = 64;
	localparam int TICKET_BITS     = 16;
	localparam int SLOT_BITS       = $clog2(NUM_SLOTS);
	localparam int TOTAL_BITS      = TICKET_BITS + SLOT_BITS;
	localparam int SEED_BITS       = 31;
	localparam int SLOT_FIELD_BITS = 6;
	localparam int TIX_FIELD_BITS  = 16;
	localparam int OUT_BITS        = 22;

	// park-miller minimal standard generator
	localparam int unsigned PM_MULT = 16807;
	localparam logic [SEED_BITS-1:0] PM_MOD = 31'h7FFF_FFFF;
	localparam logic [SEED_BITS-1:0] SEED_INIT = 31'd1;

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_ERASE = 2'd1,
		FUNC_SET   = 2'd2,
		FUNC_PICK  = 2'd3
	} lwp_func_t;

	typedef struct packed {
		lwp_func_t                   func;
		logic [SLOT_FIELD_BITS-1:0]  task_slot;
		logic [TIX_FIELD_BITS-1:0]   tickets;
		logic                        boosted;
	} lwp_cmd_t;

	typedef struct packed {
		logic                        winner_valid;
		logic [SLOT_FIELD_BITS-1:0]  winner_slot;
		logic [OUT_BITS-1:0]         ticket_total;
		logic [OUT_BITS-1:0]         drawn_ticket;
	} lwp_result_t;

endpackage

FILE: rtl/core/lwp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lwp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/lwp_mod.sv
// restoring remainder unit, one quotient bit per cycle
// depends on lwp_pkg
module lwp_mod (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lwp_pkg::SEED_BITS-1:0]   dividend,
	input  logic [lwp_pkg::TOTAL_BITS-1:0]  divisor,
	output logic                            done,
	output logic [lwp_pkg::TOTAL_BITS-1:0]  remainder
);

	import lwp_pkg::*;

	localparam int CNT_BITS = $clog2(SEED_BITS);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [SEED_BITS-1:0]  dvd_q;
	logic [TOTAL_BITS-1:0] dvs_q;
	logic [TOTAL_BITS-1:0] rem_q;
	logic [TOTAL_BITS:0]   rem_ext;
	logic [TOTAL_BITS-1:0] rem_next;

	// partial remainder stays below the divisor, so the difference fits
	always_comb begin
		rem_ext = {rem_q, dvd_q[SEED_BITS-1]};
		if (rem_ext >= {1'b0, dvs_q}) begin
			rem_next = TOTAL_BITS'(rem_ext - {1'b0, dvs_q});
		end else begin
			rem_next = TOTAL_BITS'(rem_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(SEED_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[SEED_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/core/lottery_winner_picker.sv
// top level of the lottery winner picker: sequencer around the slot ram
// depends on lwp_pkg, lwp_ram, lwp_mod
//
// Usage: present a command on cmd and raise start; it is taken on a rising
// edge where start is high and busy is low. Each command gives exactly one
// result beat on result, flagged by done for a single cycle. The receiver
// cannot stall, so the result must be captured in that cycle.
// Slot state (ticket count and queued mark) lives in one ram, one word per
// slot, with a flop valid bit per word so reset clears every slot at once.
// Steps from accept to done:
//   add, erase, set tickets : ram read, write back, result
//   boosted pick            : result only
//   pick, empty queue       : ticket sum scan, result
//   pick                    : sum scan, seed step, remainder, winner walk
// A pick with tickets to draw from walks the slots twice through the single
// ram read port, once to total the tickets and once to find the winner; its
// draw uses a remainder unit that resolves one bit per cycle over the 31-bit seed.
// One command is in flight at a time; busy stays high until its result.
// Reset is asynchronous: all slots unqueued with zero tickets, seed one,
// no result pending, and a command may be taken on the first edge after.
module lottery_winner_picker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lwp_pkg::lwp_cmd_t    cmd,
	output logic                 done,
	output lwp_pkg::lwp_result_t result
);

	import lwp_pkg::*;

	localparam logic [SLOT_BITS:0] IDX_END = (SLOT_BITS + 1)'(NUM_SLOTS);

	typedef struct packed {
		logic                   queued;
		logic [TICKET_BITS-1:0] tickets;
	} lwp_entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD_RD,
		S_CMD_WR,
		S_RESP,
		S_SUM,
		S_GEN_LO,
		S_GEN_HI,
		S_GEN_FIX,
		S_MOD_GO,
		S_MOD_WAIT,
		S_WALK
	} state_t;

	state_t                 state_q;
	lwp_cmd_t               cmd_q;
	logic [NUM_SLOTS-1:0]   ent_valid_q;
	logic [SLOT_BITS:0]     idx_q;
	logic                   rd_vld_s1;
	logic [SLOT_BITS-1:0]   rd_idx_s1;
	logic [TOTAL_BITS-1:0]  acc_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic [TOTAL_BITS-1:0]  draw_q;
	logic [SEED_BITS-1:0]   seed_q;
	logic [SEED_BITS-1:0]   prod_q;
	logic [SEED_BITS-1:0]   lo_q;
	logic                   done_q;
	lwp_result_t            result_q;

	logic                   ram_we;
	logic [SLOT_BITS-1:0]   ram_waddr;
	lwp_entry_t             ram_wdata;
	logic                   ram_re;
	logic [SLOT_BITS-1:0]   ram_raddr;
	logic [TICKET_BITS:0]   ram_rdata;
	lwp_entry_t             rd_ent;
	logic [TOTAL_BITS-1:0]  acc_next;
	logic                   walk_hit;
	logic                   scan_live;
	logic                   scan_end;
	logic [SLOT_BITS-1:0]   cmd_slot;
	logic                   cmd_slot_ok;

	logic [15:0]            mul_a;
	logic [SEED_BITS-1:0]   mul_p;
	logic [SEED_BITS+1:0]   pm_sum;
	logic [SEED_BITS+1:0]   pm_fix;

	logic                   div_start;
	logic                   div_done;
	logic [TOTAL_BITS-1:0]  div_rem;

	lwp_ram #(
		.WIDTH (TICKET_BITS + 1),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lwp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (seed_q),
		.divisor   (total_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign cmd_slot    = SLOT_BITS'(cmd_q.task_slot);
	assign cmd_slot_ok = ({1'b0, cmd_q.task_slot} < NUM_SLOTS);

	// never-written words read as an empty slot
	assign rd_ent   = ent_valid_q[rd_idx_s1] ? lwp_entry_t'(ram_rdata) : '0;
	assign acc_next = acc_q + TOTAL_BITS'(rd_ent.tickets);
	assign walk_hit = rd_vld_s1 && rd_ent.queued && (acc_next >= draw_q);

	assign scan_live = (state_q == S_SUM) || (state_q == S_WALK);
	assign scan_end  = (idx_q == IDX_END) && !rd_vld_s1;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[SLOT_BITS-1:0];
		if (state_q == S_CMD_RD) begin
			ram_re    = 1'b1;
			ram_raddr = cmd_slot;
		end else if (scan_live && (idx_q != IDX_END)) begin
			ram_re = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = rd_ent;
		if (state_q == S_CMD_WR) begin
			ram_we = 1'b1;
			case (cmd_q.func)
				FUNC_ADD:   ram_wdata.queued  = 1'b1;
				FUNC_ERASE: ram_wdata.queued  = 1'b0;
				FUNC_SET:   ram_wdata.tickets = TICKET_BITS'(cmd_q.tickets);
				default:    ram_wdata = rd_ent;
			endcase
		end else if ((state_q == S_WALK) && walk_hit) begin
			// winner leaves the queue
			ram_we           = 1'b1;
			ram_wdata.queued = 1'b0;
		end
	end

	// one shared 15x16 multiplier, low half of the seed first
	assign mul_a = (state_q == S_GEN_LO) ? seed_q[15:0] : {1'b0, seed_q[30:16]};
	assign mul_p = SEED_BITS'(mul_a) * SEED_BITS'(PM_MULT);

	// fold the high product back in: 2^31 == 1 modulo the prime
	always_comb begin
		pm_sum = (SEED_BITS + 2)'(lo_q)
			+ (SEED_BITS + 2)'({prod_q[14:0], 16'd0})
			+ (SEED_BITS + 2)'(prod_q[SEED_BITS-1:15]);
		if (pm_sum > (SEED_BITS + 2)'(PM_MOD)) begin
			pm_fix = pm_sum - (SEED_BITS + 2)'(PM_MOD);
		end else begin
			pm_fix = pm_sum;
		end
	end

	assign div_start = (state_q == S_MOD_GO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ent_valid_q <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			seed_q      <= SEED_INIT;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						if (cmd.func != FUNC_PICK) begin
							state_q <= S_CMD_RD;
						end else if (cmd.boosted) begin
							state_q <= S_RESP;
						end else begin
							idx_q     <= '0;
							rd_vld_s1 <= 1'b0;
							acc_q     <= '0;
							state_q   <= S_SUM;
						end
					end
				end
				S_CMD_RD: begin
					rd_idx_s1 <= cmd_slot;
					state_q   <= cmd_slot_ok ? S_CMD_WR : S_RESP;
				end
				S_CMD_WR: begin
					ent_valid_q[rd_idx_s1] <= 1'b1;
					state_q                <= S_RESP;
				end
				S_RESP: begin
					result_q <= '0;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_SUM: begin
					rd_vld_s1 <= (idx_q != IDX_END);
					rd_idx_s1 <= idx_q[SLOT_BITS-1:0];
					if (idx_q != IDX_END) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_vld_s1 && rd_ent.queued) begin
						acc_q <= acc_next;
					end
					if (scan_end) begin
						total_q <= acc_q;
						if (acc_q == '0) begin
							// nothing to draw from: draw is one, seed holds
							result_q.winner_valid <= 1'b0;
							result_q.winner_slot  <= '0;
							result_q.ticket_total <= '0;
							result_q.drawn_ticket <= OUT_BITS'(1);
							done_q                <= 1'b1;
							state_q               <= S_IDLE;
						end else begin
							state_q <= S_GEN_LO;
						end
					end
				end
				S_GEN_LO: begin
					prod_q  <= mul_p;
					state_q <= S_GEN_HI;
				end
				S_GEN_HI: begin
					lo_q    <= prod_q;
					prod_q  <= mul_p;
					state_q <= S_GEN_FIX;
				end
				S_GEN_FIX: begin
					seed_q  <= pm_fix[SEED_BITS-1:0] & PM_MOD;
					state_q <= S_MOD_GO;
				end
				S_MOD_GO: begin
					state_q <= S_MOD_WAIT;
				end
				S_MOD_WAIT: begin
					if (div_done) begin
						draw_q    <= div_rem + 1'b1;
						acc_q     <= '0;
						idx_q     <= '0;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					rd_vld_s1 <= (idx_q != IDX_END);
					rd_idx_s1 <= idx_q[SLOT_BITS-1:0];
					if (idx_q != IDX_END) begin
						idx_q <= idx_q + 1'b1;
					end
					if (walk_hit) begin
						result_q.winner_valid <= 1'b1;
						result_q.winner_slot  <= SLOT_FIELD_BITS'(rd_idx_s1);
						result_q.ticket_total <= OUT_BITS'(total_q);
						result_q.drawn_ticket <= OUT_BITS'(draw_q);
						done_q                <= 1'b1;
						state_q               <= S_IDLE;
					end else begin
						if (rd_vld_s1 && rd_ent.queued) begin
							acc_q <= acc_next;
						end
						if (scan_end) begin
							result_q.winner_valid <= 1'b0;
							result_q.winner_slot  <= '0;
							result_q.ticket_total <= OUT_BITS'(total_q);
							result_q.drawn_ticket <= OUT_BITS'(draw_q);
							done_q                <= 1'b1;
							state_q               <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/core/lwp_checker.sv
// port-level checks for the lottery winner picker, bound to the top level
// depends on lwp_pkg and lottery_winner_picker_macros.svh
`include "lottery_winner_picker_macros.svh"

module lwp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input lwp_pkg::lwp_result_t result
);

	import lwp_pkg::*;

	// an accepted command always occupies the block, raising busy
	`LWP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

	// every command ends with exactly one result beat as busy drops
	`LWP_ASSERT_IMP(a_fall_done, $fell(busy), done, "busy dropped without a result beat")

	`LWP_ASSERT_NXT(a_done_pulse, done, !done, "result beat held for more than one cycle")

	// no winner means slot zero
	`LWP_ASSERT_IMP(a_no_winner_slot, done && !result.winner_valid,
		result.winner_slot == '0, "slot reported without a winner")

	// a winning draw lies between one and the ticket total
	`LWP_ASSERT_IMP(a_draw_range, done && result.winner_valid,
		(result.drawn_ticket != '0) && (result.drawn_ticket <= result.ticket_total),
		"winning draw outside the ticket total")

endmodule

bind lottery_winner_picker lwp_checker u_lwp_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for lottery_winner_picker: clocked driver and monitor
// depends on lwp_pkg and the lottery_winner_picker rtl
module testbench;

	import lwp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned TAIL_CYCLES = 2 * NUM_SLOTS + 60;
	localparam int unsigned PHASE_ITEMS = 440;
	localparam int unsigned MAX_PRINTED = 100;

	typedef struct {
		lwp_cmd_t    cmd;
		int unsigned gap_pct;
	} pending_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	lwp_cmd_t    cmd = '0;
	logic        done;
	lwp_result_t result;

	// shadow copy of the slot table and generator
	logic [TICKET_BITS-1:0] slot_tickets [NUM_SLOTS];
	logic                   slot_queued [NUM_SLOTS];
	logic [SEED_BITS-1:0]   gen_seed;

	pending_cmd_t cmd_backlog[$];
	lwp_result_t  expected_results[$];

	int unsigned n_cycles = 0;
	int unsigned n_errors = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_winners = 0;
	int unsigned n_boosted = 0;
	logic [OUT_BITS-1:0] peak_total = '0;

	lottery_winner_picker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) n_cycles <= n_cycles + 1;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("mismatch at cycle %0d: %s got %0d expected %0d",
				n_cycles, what, got, want);
	endtask

	// applies one command to the shadow table and returns the result beat it gives
	function automatic lwp_result_t lottery_outcome(lwp_cmd_t c);
		lwp_result_t         r;
		logic [OUT_BITS-1:0] total;
		logic [OUT_BITS-1:0] running;
		logic [OUT_BITS-1:0] draw;
		r = '0;
		case (c.func)
			FUNC_ADD:   slot_queued[c.task_slot] = 1'b1;
			FUNC_ERASE: slot_queued[c.task_slot] = 1'b0;
			FUNC_SET:   slot_tickets[c.task_slot] = c.tickets;
			FUNC_PICK: begin
				if (c.boosted) begin
					n_boosted++;
				end else begin
					total = '0;
					for (int i = 0; i < NUM_SLOTS; i++)
						if (slot_queued[i])
							total += OUT_BITS'(slot_tickets[i]);
					// empty or all-zero queue: generator holds, draw is one
					if (total != 0) begin
						gen_seed = SEED_BITS'((64'(gen_seed) * PM_MULT) % 64'(PM_MOD));
						draw = OUT_BITS'(64'(gen_seed) % 64'(total) + 1);
					end else begin
						draw = OUT_BITS'(1);
					end
					running = '0;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (slot_queued[i]) begin
							running += OUT_BITS'(slot_tickets[i]);
							if (running >= draw) begin
								slot_queued[i] = 1'b0;
								r.winner_valid = 1'b1;
								r.winner_slot = SLOT_FIELD_BITS'(i);
								break;
							end
						end
					end
					r.ticket_total = total;
					r.drawn_ticket = draw;
					if (r.winner_valid)
						n_winners++;
					if (total > peak_total)
						peak_total = total;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_cmd(input lwp_func_t f, input int unsigned slot,
			input int unsigned tix, input bit boost, input int unsigned gap);
		pending_cmd_t p;
		p.cmd.func = f;
		p.cmd.task_slot = SLOT_FIELD_BITS'(slot);
		p.cmd.tickets = TIX_FIELD_BITS'(tix);
		p.cmd.boosted = boost;
		p.gap_pct = gap;
		cmd_backlog.push_back(p);
	endtask

	// random command; fields that the operation ignores carry noise
	task automatic queue_random_cmd(input int unsigned gap);
		int unsigned pick_kind;
		int unsigned tix;
		pick_kind = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: tix = 0;
			1: tix = 16'hFFFF;
			2: tix = $urandom_range(1, 255);
			default: tix = $urandom_range(0, 16'hFFFF);
		endcase
		if (pick_kind < 28)
			queue_cmd(FUNC_SET, $urandom_range(0, 63), tix, 1'($urandom_range(0, 1)), gap);
		else if (pick_kind < 55)
			queue_cmd(FUNC_ADD, $urandom_range(0, 63), tix, 1'($urandom_range(0, 1)), gap);
		else if (pick_kind < 68)
			queue_cmd(FUNC_ERASE, $urandom_range(0, 63), tix, 1'($urandom_range(0, 1)),
				gap);
		else
			queue_cmd(FUNC_PICK, $urandom_range(0, 63), tix,
				$urandom_range(0, 9) == 0, gap);
	endtask

	// every slot full and queued, then a run of picks: drives the total to its top
	task automatic queue_full_table(input int unsigned gap);
		for (int s = 0; s < NUM_SLOTS; s++) begin
			queue_cmd(FUNC_SET, s, 16'hFFFF, 1'($urandom_range(0, 1)), gap);
			queue_cmd(FUNC_ADD, s, $urandom_range(0, 16'hFFFF), 1'($urandom_range(0, 1)),
				gap);
		end
		for (int k = 0; k < 8; k++)
			queue_cmd(FUNC_PICK, $urandom_range(0, 63), $urandom_range(0, 16'hFFFF), 1'b0,
				gap);
	endtask

	// driver: start is held until the beat is taken, then the next one may follow
	always @(posedge clk or negedge arst_n) begin : driver
		logic taken;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				expected_results.push_back(lottery_outcome(cmd));
				n_accepted++;
			end
			if (start && !taken) begin
				// hold the current beat
			end else if (cmd_backlog.size() != 0 &&
					$urandom_range(0, 99) >= cmd_backlog[0].gap_pct) begin
				cmd <= cmd_backlog[0].cmd;
				cmd_backlog.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		lwp_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing pending, winner_slot",
					result.winner_slot, 0);
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (result.winner_valid !== want.winner_valid)
					report_mismatch("winner_valid", result.winner_valid, want.winner_valid);
				if (result.winner_slot !== want.winner_slot)
					report_mismatch("winner_slot", result.winner_slot, want.winner_slot);
				if (result.ticket_total !== want.ticket_total)
					report_mismatch("ticket_total", result.ticket_total, want.ticket_total);
				if (result.drawn_ticket !== want.drawn_ticket)
					report_mismatch("drawn_ticket", result.drawn_ticket, want.drawn_ticket);
			end
		end
	end

	initial begin : watchdog
		while (n_cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("run timed out after %0d cycles", n_cycles);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int unsigned gap_rates [3];
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_tickets[s] = '0;
			slot_queued[s] = 1'b0;
		end
		gen_seed = SEED_INIT;
		gap_rates = '{20, 85, 0};

		// directed: empty queue, boost, zero-ticket slot, repeats, extremes
		queue_cmd(FUNC_PICK, 0, 0, 1'b0, 20);
		queue_cmd(FUNC_PICK, 0, 0, 1'b1, 20);
		queue_cmd(FUNC_SET, 0, 16'hFFFF, 1'b0, 20);
		queue_cmd(FUNC_SET, 63, 16'hFFFF, 1'b1, 20);
		queue_cmd(FUNC_SET, 1, 0, 1'b0, 20);
		queue_cmd(FUNC_ADD, 1, 16'hFFFF, 1'b1, 20);
		queue_cmd(FUNC_PICK, 63, 16'hFFFF, 1'b0, 20);
		queue_cmd(FUNC_ADD, 0, 0, 1'b0, 20);
		queue_cmd(FUNC_ADD, 0, 0, 1'b0, 20);
		queue_cmd(FUNC_ADD, 63, 0, 1'b0, 20);
		queue_cmd(FUNC_ERASE, 5, 16'hFFFF, 1'b1, 20);
		queue_cmd(FUNC_PICK, 63, 16'hFFFF, 1'b1, 20);
		queue_cmd(FUNC_PICK, 0, 0, 1'b0, 20);
		queue_cmd(FUNC_PICK, 0, 0, 1'b0, 20);
		queue_cmd(FUNC_ERASE, 63, 0, 1'b0, 20);
		queue_cmd(FUNC_ERASE, 63, 0, 1'b0, 20);
		queue_cmd(FUNC_SET, 2, 1, 1'b0, 20);
		queue_cmd(FUNC_ADD, 2, 0, 1'b0, 20);
		queue_cmd(FUNC_ADD, 1, 0, 1'b0, 20);
		queue_cmd(FUNC_PICK, 0, 0, 1'b0, 20);
		queue_cmd(FUNC_PICK, 0, 0, 1'b0, 20);

		for (int ph = 0; ph < 3; ph++) begin
			queue_full_table(gap_rates[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_random_cmd(gap_rates[ph]);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d checked, %0d picks with a winner, %0d boosted picks",
			n_accepted, n_checked, n_winners, n_boosted);
		$display("largest ticket total drawn from: %0d, mismatches: %0d",
			peak_total, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
